/* design/mfas_pkg.sv */
// mfas_pkg: shared widths, command and status structs and the divisor
// reciprocal table for the 3x3 mean filter with lower absolute sum.
// No dependencies.
`timescale 1ns / 1ps

package mfas_pkg;

    localparam int MAX_SIZE    = 32;
    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = $clog2(MAX_SIZE);
    localparam int SIZE_W      = 6;
    localparam int ACC_W       = 24;
    localparam int SUM_W       = SAMPLE_W + 4;
    localparam int MAG_W       = SUM_W - 1;
    localparam int QMAG_W      = SAMPLE_W + 1;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int NUM_BANKS   = 3;
    localparam int BANK_W      = 2;
    localparam int OUT_BITS    = SAMPLE_W + 2 * IDX_W + ACC_W;
    localparam int TDATA_W     = ((OUT_BITS + 7) / 8) * 8;
    localparam int S_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

    localparam logic [BANK_W-1:0] BANK_0 = 2'd0;
    localparam logic [BANK_W-1:0] BANK_1 = 2'd1;
    localparam logic [BANK_W-1:0] BANK_2 = 2'd2;

    typedef struct packed {
        logic                   wr_en;
        logic [BANK_W-1:0]      wr_bank;
        logic [IDX_W-1:0]       wr_col;
        logic                   rd_en;
        logic [IDX_W-1:0]       rd_col;
        logic                   col_ok;
        logic                   first;
        logic [NUM_BANKS-1:0]   bank_mask;
        logic [1:0]             row_cnt;
        logic [1:0]             col_cnt;
        logic                   mul_en;
        logic                   emit;
        logic [IDX_W-1:0]       out_row;
        logic [IDX_W-1:0]       out_col;
        logic                   last;
        logic                   clear_acc;
    } mfas_cmd_t;

    typedef struct packed {
        logic out_free;
    } mfas_sts_t;

    // ceil(2^23 / count) for the neighbour counts that occur
    function automatic logic [RECIP_W-1:0] recip_of(input logic [1:0] rows,
                                                    input logic [1:0] cols);
        logic [3:0] cnt;
        cnt = 4'(rows) * 4'(cols);
        case (cnt)
            4'd1:    recip_of = 24'd8388608;
            4'd2:    recip_of = 24'd4194304;
            4'd3:    recip_of = 24'd2796203;
            4'd4:    recip_of = 24'd2097152;
            4'd6:    recip_of = 24'd1398102;
            4'd9:    recip_of = 24'd932068;
            default: recip_of = 24'd8388608;
        endcase
    endfunction

    function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] b);
        bank_inc = (b == BANK_2) ? BANK_0 : b + 2'd1;
    endfunction

    function automatic logic [BANK_W-1:0] bank_dec(input logic [BANK_W-1:0] b);
        bank_dec = (b == BANK_0) ? BANK_2 : b - 2'd1;
    endfunction

endpackage

/* design/mfas_ctrl.sv */
// mfas_ctrl: controller for the mean filter; tracks the matrix position,
// queues the results each request releases and sequences the datapath.
// Depends on mfas_pkg.
`timescale 1ns / 1ps

module mfas_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      cfg_wr_en,
    input  logic [5:0]                cfg_wr_data,
    output mfas_pkg::mfas_cmd_t       cmd,
    input  mfas_pkg::mfas_sts_t       sts
);
    import mfas_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PICK = 6'b000010,
        ST_READ = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_MULT = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]    in_row_reg, in_row_next;
    logic [IDX_W-1:0]    in_col_reg, in_col_next;
    logic [BANK_W-1:0]   in_bank_reg, in_bank_next;
    logic [IDX_W-1:0]    lat_row_reg, lat_row_next;
    logic [IDX_W-1:0]    lat_col_reg, lat_col_next;
    logic [BANK_W-1:0]   lat_bank_reg, lat_bank_next;
    logic                pend_a_reg, pend_a_next;
    logic                pend_b_reg, pend_b_next;
    logic                pend_c_reg, pend_c_next;
    logic [IDX_W-1:0]    flush_col_reg, flush_col_next;
    logic [IDX_W-1:0]    er_reg, er_next;
    logic [IDX_W-1:0]    ec_reg, ec_next;
    logic [BANK_W-1:0]   cb_reg, cb_next;
    logic                last_reg, last_next;
    logic [1:0]          step_reg, step_next;

    logic [SIZE_W-1:0]   n_eff;
    logic [IDX_W-1:0]    nm1;
    logic                accept;
    logic                has_up;
    logic                has_down;
    logic                has_left;
    logic                has_right;

    always_comb begin
        if (size_reg == '0) begin
            n_eff = SIZE_W'(1);
        end else if (size_reg > SIZE_W'(MAX_SIZE)) begin
            n_eff = SIZE_W'(MAX_SIZE);
        end else begin
            n_eff = size_reg;
        end
    end

    assign nm1       = IDX_W'(n_eff - SIZE_W'(1));
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign accept    = s_tvalid && s_tready;
    assign has_up    = (er_reg != '0);
    assign has_down  = (er_reg != nm1);
    assign has_left  = (ec_reg != '0);
    assign has_right = (ec_reg != nm1);

    always_comb begin
        state_next     = state_reg;
        size_next      = size_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        in_bank_next   = in_bank_reg;
        lat_row_next   = lat_row_reg;
        lat_col_next   = lat_col_reg;
        lat_bank_next  = lat_bank_reg;
        pend_a_next    = pend_a_reg;
        pend_b_next    = pend_b_reg;
        pend_c_next    = pend_c_reg;
        flush_col_next = flush_col_reg;
        er_next        = er_reg;
        ec_next        = ec_reg;
        cb_next        = cb_reg;
        last_next      = last_reg;
        step_next      = step_reg;

        cmd           = '0;
        cmd.wr_bank   = in_bank_reg;
        cmd.wr_col    = in_col_reg;
        cmd.bank_mask = (NUM_BANKS'(1) << cb_reg)
                      | (has_up   ? (NUM_BANKS'(1) << bank_dec(cb_reg)) : '0)
                      | (has_down ? (NUM_BANKS'(1) << bank_inc(cb_reg)) : '0);
        cmd.row_cnt   = 2'd1 + 2'(has_up) + 2'(has_down);
        cmd.col_cnt   = 2'd1 + 2'(has_left) + 2'(has_right);
        cmd.out_row   = er_reg;
        cmd.out_col   = ec_reg;
        cmd.last      = last_reg;
        cmd.rd_col    = ec_reg;

        if (cfg_wr_en) begin
            size_next     = cfg_wr_data;
            in_row_next   = '0;
            in_col_next   = '0;
            in_bank_next  = BANK_0;
            cmd.clear_acc = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.wr_en      = 1'b1;
                    lat_row_next   = in_row_reg;
                    lat_col_next   = in_col_reg;
                    lat_bank_next  = in_bank_reg;
                    pend_a_next    = (in_row_reg != '0) && (in_col_reg != '0);
                    pend_b_next    = (in_row_reg != '0) && (in_col_reg == nm1);
                    pend_c_next    = (in_row_reg == nm1) && (in_col_reg == nm1);
                    flush_col_next = '0;
                    if (in_col_reg == nm1) begin
                        in_col_next = '0;
                        if (in_row_reg == nm1) begin
                            in_row_next  = '0;
                            in_bank_next = BANK_0;
                        end else begin
                            in_row_next  = in_row_reg + IDX_W'(1);
                            in_bank_next = bank_inc(in_bank_reg);
                        end
                    end else begin
                        in_col_next = in_col_reg + IDX_W'(1);
                    end
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                step_next  = 2'd0;
                state_next = ST_READ;
                if (pend_a_reg) begin
                    pend_a_next = 1'b0;
                    er_next     = lat_row_reg - IDX_W'(1);
                    ec_next     = lat_col_reg - IDX_W'(1);
                    cb_next     = bank_dec(lat_bank_reg);
                    last_next   = 1'b0;
                end else if (pend_b_reg) begin
                    pend_b_next = 1'b0;
                    er_next     = lat_row_reg - IDX_W'(1);
                    ec_next     = nm1;
                    cb_next     = bank_dec(lat_bank_reg);
                    last_next   = 1'b0;
                end else if (pend_c_reg) begin
                    er_next        = nm1;
                    ec_next        = flush_col_reg;
                    cb_next        = lat_bank_reg;
                    last_next      = (flush_col_reg == nm1);
                    flush_col_next = flush_col_reg + IDX_W'(1);
                    if (flush_col_reg == nm1) begin
                        pend_c_next = 1'b0;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                cmd.first = (step_reg == 2'd0);
                case (step_reg)
                    2'd0: begin
                        cmd.rd_col = ec_reg - IDX_W'(1);
                        cmd.col_ok = has_left;
                    end
                    2'd1: begin
                        cmd.rd_col = ec_reg;
                        cmd.col_ok = 1'b1;
                    end
                    default: begin
                        cmd.rd_col = ec_reg + IDX_W'(1);
                        cmd.col_ok = has_right;
                    end
                endcase
                if (step_reg == 2'd2) begin
                    state_next = ST_SUM;
                end else begin
                    step_next = step_reg + 2'd1;
                end
            end
            ST_SUM: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mul_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_PICK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_W'(MAX_SIZE);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_bank_reg   <= BANK_0;
            pend_a_reg    <= 1'b0;
            pend_b_reg    <= 1'b0;
            pend_c_reg    <= 1'b0;
            flush_col_reg <= '0;
            step_reg      <= 2'd0;
        end else begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            in_bank_reg   <= in_bank_next;
            pend_a_reg    <= pend_a_next;
            pend_b_reg    <= pend_b_next;
            pend_c_reg    <= pend_c_next;
            flush_col_reg <= flush_col_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        lat_row_reg  <= lat_row_next;
        lat_col_reg  <= lat_col_next;
        lat_bank_reg <= lat_bank_next;
        er_reg       <= er_next;
        ec_reg       <= ec_next;
        cb_reg       <= cb_next;
        last_reg     <= last_next;
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(pend_a_reg || pend_b_reg || pend_c_reg))
        else $error("idle with results still queued");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_row_reg <= nm1) && (in_col_reg <= nm1))
        else $error("input position beyond matrix size");

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over an untaken one");

    a_last_ends_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |-> !pend_a_reg && !pend_b_reg && !pend_c_reg)
        else $error("final result issued with more queued");
`endif

endmodule

/* design/mfas_datapath.sv */
// mfas_datapath: three row line stores, column accumulation, reciprocal
// divide, below-diagonal absolute sum and the output register.
// Depends on mfas_pkg.
`timescale 1ns / 1ps

module mfas_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [mfas_pkg::SAMPLE_W-1:0]  sample,
    input  mfas_pkg::mfas_cmd_t            cmd,
    output mfas_pkg::mfas_sts_t            sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mfas_pkg::TDATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);
    import mfas_pkg::*;

    logic [SAMPLE_W-1:0]        rd_q [NUM_BANKS];
    logic                       pipe_vld_reg;
    logic                       pipe_first_reg;
    logic                       pipe_ok_reg;
    logic signed [SUM_W-1:0]    col_sum;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [MAG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod;
    logic [QMAG_W-1:0]          qmag_reg;
    logic                       neg_reg;
    logic [QMAG_W-1:0]          q_signed;
    logic [ACC_W:0]             acc_sum;
    logic [ACC_W-1:0]           acc_sat;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic                       m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]        smoothed_reg;
    logic [IDX_W-1:0]           out_row_reg;
    logic [IDX_W-1:0]           out_col_reg;
    logic                       last_reg;
    logic [ACC_W-1:0]           lower_reg;

    // one line store per row modulo three
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [SAMPLE_W-1:0] mem [MAX_SIZE];

        always_ff @(posedge aclk) begin
            if (cmd.wr_en && (cmd.wr_bank == BANK_W'(b))) begin
                mem[cmd.wr_col] <= sample;
            end
            if (cmd.rd_en) begin
                rd_q[b] <= mem[cmd.rd_col];
            end
        end
    end

    always_comb begin
        col_sum = '0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (cmd.bank_mask[b]) begin
                col_sum = col_sum + SUM_W'(signed'(rd_q[b]));
            end
        end
        sum_next = sum_reg;
        if (pipe_vld_reg) begin
            sum_next = (pipe_first_reg ? SUM_W'(0) : sum_reg)
                     + (pipe_ok_reg ? col_sum : SUM_W'(0));
        end
    end

    assign mag  = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
    assign prod = PROD_W'(mag) * PROD_W'(recip_of(cmd.row_cnt, cmd.col_cnt));

    assign q_signed = neg_reg ? (~qmag_reg + QMAG_W'(1)) : qmag_reg;
    assign acc_sum  = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(qmag_reg);
    assign acc_sat  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    always_comb begin
        acc_next = acc_reg;
        if (cmd.clear_acc) begin
            acc_next = '0;
        end else if (cmd.emit) begin
            if (cmd.last) begin
                acc_next = '0;
            end else if (cmd.out_row > cmd.out_col) begin
                acc_next = acc_sat;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_vld_reg <= 1'b0;
            acc_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            pipe_vld_reg <= cmd.rd_en;
            acc_reg      <= acc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_first_reg <= cmd.first;
        pipe_ok_reg    <= cmd.col_ok;
        sum_reg        <= sum_next;
        if (cmd.mul_en) begin
            qmag_reg <= prod[RECIP_SHIFT +: QMAG_W];
            neg_reg  <= sum_reg[SUM_W-1];
        end
        if (cmd.emit) begin
            smoothed_reg <= q_signed[SAMPLE_W-1:0];
            out_row_reg  <= cmd.out_row;
            out_col_reg  <= cmd.out_col;
            last_reg     <= cmd.last;
            if (!cmd.last) begin
                lower_reg <= '0;
            end else if (cmd.out_row > cmd.out_col) begin
                lower_reg <= acc_sat;
            end else begin
                lower_reg <= acc_reg;
            end
        end
    end

    assign sts.out_free = !m_valid_reg || m_tready;
    assign m_tvalid     = m_valid_reg;
    assign m_tlast      = last_reg;
    assign m_tdata      = TDATA_W'({lower_reg, out_col_reg, out_row_reg, smoothed_reg});

endmodule

/* design/mean_filter_3x3_with_lower_abs_sum_core.sv */
// mean_filter_3x3_with_lower_abs_sum_core: top level of the 3x3 mean
// filter; joins the controller and the datapath. Depends on mfas_pkg,
// mfas_ctrl and mfas_datapath.
//
// Usage: matrix elements enter row-major on the s_ channel, one signed
// sample per request. Smoothed elements leave on the m_ channel in
// row-major order one row behind the input; m_tlast marks the final
// element, whose lower_abs_sum field holds the sum of absolute smoothed
// values below the main diagonal (zero on all other results).
// cfg_wr_en writes the matrix size (1 to 32) and restarts the matrix.
// Timing: a request is taken when the block is idle and cfg_wr_en is low;
// each result it releases then passes through select, three column reads
// of the three line stores, sum, reciprocal multiply and output load. A
// request releases 0, 1 or 2 results mid-matrix and up to n + 2 on the
// final element; the next request is not taken until all of them are
// loaded. Each line store has one read port, so the column reads go one
// column at a time.
// Reset: matrix size returns to 32, position and sum clear; line stores
// hold no reset value. A stalled m_tready holds the result in the output
// register and the block waits before loading the next one.
`timescale 1ns / 1ps

module mean_filter_3x3_with_lower_abs_sum_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mfas_pkg::S_TDATA_W-1:0]  s_tdata,   // [15:0] sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] smoothed, [20:16] out_row, [25:21] out_col, [49:26] lower_abs_sum
    output logic [mfas_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [5:0]                      cfg_wr_data
);
    import mfas_pkg::*;

    mfas_cmd_t cmd;
    mfas_sts_t sts;

    mfas_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    mfas_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sample   (s_tdata[SAMPLE_W-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
